### design/indexed_list_engine_macros.svh
// Assertion macros shared by the indexed list engine checkers.
// Depends on nothing; each use expects signals clk and arst_n in scope.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("indexed list engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ILE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("indexed list engine: next-cycle check failed");

`endif

### design/ile_pkg.sv
// Shared types and constants for the indexed list engine.
// Used by the list cell and the top level; depends on nothing.
package ile_pkg;

	localparam int DATA_W           = 32;
	localparam int POS_W            = 5;
	localparam int OP_W             = 3;
	localparam int STATUS_W         = 2;
	localparam int COUNT_OUT_W      = 5;
	localparam int DEFAULT_CAPACITY = 16;

	// Operation codes carried by the operation field.
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_GET    = 3'd3,
		OP_SET    = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Broadcast command to every cell; each flag is already qualified by
	// acceptance and by the range and capacity checks.
	typedef struct packed {
		logic clear;
		logic append;
		logic insert;
		logic remove;
		logic set;
	} cell_ctrl_t;

endpackage

### design/ile_cell.sv
// One storage cell of the list chain: holds a single entry and updates it
// from the broadcast command and its two neighbors. Depends on ile_pkg.
module ile_cell #(
	parameter int INDEX = 0,
	parameter int IDX_W = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ile_pkg::cell_ctrl_t                ctrl,
	input  logic [IDX_W-1:0]                   pos,
	input  logic [IDX_W-1:0]                   cnt,
	input  logic signed [ile_pkg::DATA_W-1:0]  value,
	input  logic signed [ile_pkg::DATA_W-1:0]  left_entry,
	input  logic signed [ile_pkg::DATA_W-1:0]  right_entry,
	output logic signed [ile_pkg::DATA_W-1:0]  entry
);

	localparam logic [IDX_W-1:0] IDX      = IDX_W'(INDEX);
	localparam logic [IDX_W-1:0] IDX_NEXT = IDX_W'(INDEX + 1);

	logic signed [ile_pkg::DATA_W-1:0] entry_q;
	logic signed [ile_pkg::DATA_W-1:0] entry_next;
	logic                              entry_we;

	// Pick this cell's next value; order matters only between the flags,
	// which the top level makes mutually exclusive anyway.
	always_comb begin
		entry_we   = 1'b0;
		entry_next = entry_q;
		priority if (ctrl.clear) begin
			entry_we   = 1'b1;
			entry_next = '0;
		end else if (ctrl.append) begin
			if (IDX == cnt) begin
				entry_we   = 1'b1;
				entry_next = value;
			end
		end else if (ctrl.insert) begin
			if (IDX == pos) begin
				entry_we   = 1'b1;
				entry_next = value;
			end else if (IDX > pos && IDX <= cnt) begin
				entry_we   = 1'b1;
				entry_next = left_entry;
			end
		end else if (ctrl.remove) begin
			if (IDX >= pos && IDX_NEXT < cnt) begin
				entry_we   = 1'b1;
				entry_next = right_entry;
			end else if (IDX_NEXT == cnt) begin
				entry_we   = 1'b1;
				entry_next = '0;
			end
		end else if (ctrl.set) begin
			if (IDX == pos) begin
				entry_we   = 1'b1;
				entry_next = value;
			end
		end
	end

	// Entry storage, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (entry_we) begin
			entry_q <= entry_next;
		end
	end

	assign entry = entry_q;

endmodule

### design/indexed_list_engine.sv
// Indexed list engine: an ordered list of signed words kept in a row of cells.
// Depends on ile_pkg and instantiates ile_cell.
//
// Usage:
//   The request channel (in_valid/in_ready) carries operation, position and
//   item_value. The result channel (out_valid/out_ready) returns read_value,
//   status, entry_count and is_empty, one result per request, in order.
//   The result of an accepted request is in the output register from the next
//   cycle on. Throughput is one request per cycle while the receiver keeps
//   up; every cell updates in parallel from the broadcast command and its
//   neighbors, and the count register closes the loop.
//   A request is taken while the output register is empty or being drained
//   in the same cycle; when the receiver stalls, the result holds and
//   in_ready drops until it is taken.
//   Reset empties the list, zeroes every cell and drops out_valid; the block
//   takes requests as soon as reset is released.
//   Get, set and remove need a position below the count, insert one not
//   above it; on a full list, append and an in-range insert report full.
module indexed_list_engine #(
	parameter int CAPACITY = ile_pkg::DEFAULT_CAPACITY
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ile_pkg::OP_W-1:0]             operation,
	input  logic [ile_pkg::POS_W-1:0]            position,
	input  logic signed [ile_pkg::DATA_W-1:0]    item_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [ile_pkg::DATA_W-1:0]    read_value,
	output logic [ile_pkg::STATUS_W-1:0]         status,
	output logic [ile_pkg::COUNT_OUT_W-1:0]      entry_count,
	output logic                                 is_empty
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam logic [IDX_W-1:0] CAP = IDX_W'(CAPACITY);

	logic                              accept;
	logic [IDX_W-1:0]                  count_q;
	logic [IDX_W-1:0]                  count_next;
	logic [IDX_W-1:0]                  pos_ext;
	logic                              over_count;
	logic                              at_or_over_count;
	logic                              full;
	ile_pkg::cell_ctrl_t               ctrl_dec;
	ile_pkg::cell_ctrl_t               ctrl;
	ile_pkg::status_t                  status_dec;
	logic signed [ile_pkg::DATA_W-1:0] read_dec;
	logic signed [ile_pkg::DATA_W-1:0] entry_w [CAPACITY];

	logic                              out_valid_q;
	logic signed [ile_pkg::DATA_W-1:0] read_value_q;
	logic [ile_pkg::STATUS_W-1:0]      status_q;
	logic [ile_pkg::COUNT_OUT_W-1:0]   entry_count_q;
	logic                              is_empty_q;

	// Handshake: the output register parts the two channels.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Range and capacity checks against the current count.
	assign pos_ext          = IDX_W'(position);
	assign over_count       = pos_ext > count_q;
	assign at_or_over_count = pos_ext >= count_q;
	assign full             = count_q >= CAP;

	// Decode the request into a cell command, a status and the new count.
	always_comb begin
		ctrl_dec   = '0;
		status_dec = ile_pkg::ST_OK;
		read_dec   = '0;
		count_next = count_q;
		unique case (operation)
			ile_pkg::OP_APPEND: begin
				if (full) begin
					status_dec = ile_pkg::ST_FULL;
				end else begin
					ctrl_dec.append = 1'b1;
					count_next      = count_q + 1'b1;
				end
			end
			ile_pkg::OP_INSERT: begin
				if (over_count) begin
					status_dec = ile_pkg::ST_RANGE;
				end else if (full) begin
					status_dec = ile_pkg::ST_FULL;
				end else begin
					ctrl_dec.insert = 1'b1;
					count_next      = count_q + 1'b1;
				end
			end
			ile_pkg::OP_REMOVE: begin
				if (at_or_over_count) begin
					status_dec = ile_pkg::ST_RANGE;
				end else begin
					ctrl_dec.remove = 1'b1;
					count_next      = count_q - 1'b1;
				end
			end
			ile_pkg::OP_GET: begin
				if (at_or_over_count) begin
					status_dec = ile_pkg::ST_RANGE;
				end else begin
					read_dec = entry_w[pos_ext[ADDR_W-1:0]];
				end
			end
			ile_pkg::OP_SET: begin
				if (at_or_over_count) begin
					status_dec = ile_pkg::ST_RANGE;
				end else begin
					ctrl_dec.set = 1'b1;
				end
			end
			ile_pkg::OP_CLEAR: begin
				ctrl_dec.clear = 1'b1;
				count_next     = '0;
			end
			default: begin
				// Unused codes leave the list alone and report success.
			end
		endcase
	end

	assign ctrl = accept ? ctrl_dec : '0;

	// The row of cells; the ends see zero from their missing neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [ile_pkg::DATA_W-1:0] left_w;
		logic signed [ile_pkg::DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_inner_l
			assign left_w = entry_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner_r
			assign right_w = entry_w[i+1];
		end

		ile_cell #(
			.INDEX (i),
			.IDX_W (IDX_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.pos         (pos_ext),
			.cnt         (count_q),
			.value       (item_value),
			.left_entry  (left_w),
			.right_entry (right_w),
			.entry       (entry_w[i])
		);
	end

	// Entry count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// Result register; valid is control, the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q  <= read_dec;
			status_q      <= status_dec;
			entry_count_q <= count_next[ile_pkg::COUNT_OUT_W-1:0];
			is_empty_q    <= (count_next == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign is_empty    = is_empty_q;

endmodule

### design/ile_checker.sv
// Port-level checks for the indexed list engine, bound to the top level.
// Depends on indexed_list_engine_macros.svh, ile_pkg and the indexed_list_engine ports.
`include "indexed_list_engine_macros.svh"

module ile_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [2:0]          operation,
	input logic [4:0]          position,
	input logic signed [31:0]  item_value,
	input logic                out_valid,
	input logic                out_ready,
	input logic signed [31:0]  read_value,
	input logic [1:0]          status,
	input logic [4:0]          entry_count,
	input logic                is_empty
);

	// A stalled result transaction keeps its valid and its payload.
	`ILE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_value) && $stable(status) && $stable(entry_count) && $stable(is_empty))

	// With no result pending the block always takes a request.
	`ILE_ASSERT_IMPL(a_ready_when_drained, !out_valid, in_ready)

	// An empty list reports a zero count.
	`ILE_ASSERT_IMPL(a_empty_count, out_valid && is_empty, entry_count == 5'd0)

	// A failed operation never returns data, and status uses defined codes.
	`ILE_ASSERT_IMPL(a_error_no_data, out_valid && status != ile_pkg::ST_OK, read_value == 32'sd0 && (status == ile_pkg::ST_RANGE || status == ile_pkg::ST_FULL))

endmodule

bind indexed_list_engine ile_checker u_ile_checker (.*);

### tb/sv/ile_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the indexed list engine: watches both channels, keeps its own
// copy of the list, predicts each result and compares it field by field.
// Depends on ile_pkg only; the testbench top reads its mismatch and backlog counts.
module ile_result_checker #(
	parameter int CAPACITY = ile_pkg::DEFAULT_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [ile_pkg::OP_W-1:0]          operation,
	input  logic [ile_pkg::POS_W-1:0]         position,
	input  logic signed [ile_pkg::DATA_W-1:0] item_value,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [ile_pkg::DATA_W-1:0] read_value,
	input  logic [ile_pkg::STATUS_W-1:0]      status,
	input  logic [ile_pkg::COUNT_OUT_W-1:0]   entry_count,
	input  logic                              is_empty,
	output int                                fail_count,
	output int                                pending_count
);

	typedef struct {
		logic signed [ile_pkg::DATA_W-1:0] read_value;
		ile_pkg::status_t                  status;
		logic [ile_pkg::COUNT_OUT_W-1:0]   entry_count;
		logic                              is_empty;
	} list_result_t;

	logic signed [ile_pkg::DATA_W-1:0] list_words [CAPACITY];
	int                                list_len;
	list_result_t                      owed_results [$];

	initial fail_count = 0;

	// One line per mismatch, and the count that the top turns into a verdict.
	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		fail_count++;
		$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
	endtask

	// Applies one request to the shadow list and returns the result it must give.
	function automatic list_result_t apply_list_op(input logic [ile_pkg::OP_W-1:0] op,
		input logic [ile_pkg::POS_W-1:0] pos, input logic signed [ile_pkg::DATA_W-1:0] val);
		list_result_t res;
		res.read_value = '0;
		res.status     = ile_pkg::ST_OK;
		unique case (op)
			ile_pkg::OP_APPEND: begin
				if (list_len >= CAPACITY) begin
					res.status = ile_pkg::ST_FULL;
				end else begin
					list_words[list_len] = val;
					list_len++;
				end
			end
			ile_pkg::OP_INSERT: begin
				// The position is checked before the capacity.
				if (pos > list_len) begin
					res.status = ile_pkg::ST_RANGE;
				end else if (list_len >= CAPACITY) begin
					res.status = ile_pkg::ST_FULL;
				end else begin
					for (int i = list_len; i > pos; i--) begin
						list_words[i] = list_words[i-1];
					end
					list_words[pos] = val;
					list_len++;
				end
			end
			ile_pkg::OP_REMOVE: begin
				if (pos >= list_len) begin
					res.status = ile_pkg::ST_RANGE;
				end else begin
					for (int i = pos; i + 1 < list_len; i++) begin
						list_words[i] = list_words[i+1];
					end
					list_words[list_len-1] = '0;
					list_len--;
				end
			end
			ile_pkg::OP_GET: begin
				if (pos >= list_len) begin
					res.status = ile_pkg::ST_RANGE;
				end else begin
					res.read_value = list_words[pos];
				end
			end
			ile_pkg::OP_SET: begin
				if (pos >= list_len) begin
					res.status = ile_pkg::ST_RANGE;
				end else begin
					list_words[pos] = val;
				end
			end
			ile_pkg::OP_CLEAR: begin
				for (int i = 0; i < CAPACITY; i++) begin
					list_words[i] = '0;
				end
				list_len = 0;
			end
			default: begin
				// Spare codes leave the list alone.
			end
		endcase
		res.entry_count = list_len[ile_pkg::COUNT_OUT_W-1:0];
		res.is_empty    = (list_len == 0);
		return res;
	endfunction

	// Results are retired before requests are predicted: a request taken at an edge
	// cannot have its result taken at the same edge.
	always @(posedge clk or negedge arst_n) begin : watch_channels
		list_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				list_words[i] = '0;
			end
			list_len = 0;
			owed_results.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					report_mismatch("result with no request outstanding", read_value, '0);
				end else begin
					want = owed_results.pop_front();
					if (read_value !== want.read_value) begin
						report_mismatch("read_value", read_value, want.read_value);
					end
					if (status !== want.status) begin
						report_mismatch("status", 32'(status), 32'(want.status));
					end
					if (entry_count !== want.entry_count) begin
						report_mismatch("entry_count", 32'(entry_count),
							32'(want.entry_count));
					end
					if (is_empty !== want.is_empty) begin
						report_mismatch("is_empty", 32'(is_empty), 32'(want.is_empty));
					end
				end
			end
			if (in_valid && in_ready) begin
				owed_results.push_back(apply_list_op(operation, position, item_value));
			end
			pending_count <= owed_results.size();
		end
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the indexed list engine: clock, reset, request stimulus,
// result-side back-pressure, watchdog and verdict.
// Depends on ile_pkg, indexed_list_engine and ile_result_checker.
module tb;

	localparam int CAPACITY       = ile_pkg::DEFAULT_CAPACITY;
	localparam int RANDOM_ITEMS   = 1900;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 4;

	typedef logic [ile_pkg::POS_W-1:0] pos_t;

	// Operation codes the block does not define; they must be ignored.
	localparam logic [ile_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [ile_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic [ile_pkg::OP_W-1:0]          operation;
	logic [ile_pkg::POS_W-1:0]         position;
	logic signed [ile_pkg::DATA_W-1:0] item_value;
	logic                              out_valid;
	logic                              out_ready;
	logic signed [ile_pkg::DATA_W-1:0] read_value;
	logic [ile_pkg::STATUS_W-1:0]      status;
	logic [ile_pkg::COUNT_OUT_W-1:0]   entry_count;
	logic                              is_empty;

	int fail_total;
	int results_owed;
	int burst_left;
	int shadow_len;
	bit hold_off_req;

	indexed_list_engine #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.position   (position),
		.item_value (item_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.status     (status),
		.entry_count(entry_count),
		.is_empty   (is_empty)
	);

	ile_result_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.position     (position),
		.item_value   (item_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_value   (read_value),
		.status       (status),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.fail_count   (fail_total),
		.pending_count(results_owed)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mix of extreme words and plain random ones.
	function automatic logic signed [ile_pkg::DATA_W-1:0] random_word();
		unique case ($urandom_range(0, 11))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return '0;
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// Offers one transaction from a falling edge and returns at the falling edge
	// after it is taken. Between bursts valid drops for a random gap.
	task automatic send_item(input logic [ile_pkg::OP_W-1:0] op,
		input logic [ile_pkg::POS_W-1:0] pos, input logic signed [ile_pkg::DATA_W-1:0] val);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 12);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		position   <= pos;
		item_value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		// Rough list length, used only to steer positions and growth.
		unique case (op)
			ile_pkg::OP_APPEND: if (shadow_len < CAPACITY) shadow_len++;
			ile_pkg::OP_INSERT: if (pos <= shadow_len && shadow_len < CAPACITY) shadow_len++;
			ile_pkg::OP_REMOVE: if (pos < shadow_len) shadow_len--;
			ile_pkg::OP_CLEAR:  shadow_len = 0;
			default:            ;
		endcase
		@(negedge clk);
	endtask

	// Result side: segments of always-ready, random, mostly-stalled and toggling
	// patterns, plus one long hold-off once the random phase starts.
	initial begin : result_sink
		int seg_left;
		int mode;
		bit hold_done;
		out_ready = 1'b0;
		seg_left  = 0;
		mode      = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (seg_left == 0) begin
				mode     = $urandom_range(0, 3);
				seg_left = $urandom_range(5, 60);
			end
			seg_left--;
			unique case (mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				2:       out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ~out_ready;
			endcase
		end
	end

	// Ends the run when no transaction moves on either channel for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("** indexed_list_engine: FAILED **");
		$finish;
	end

	initial begin : stimulus
		logic [ile_pkg::OP_W-1:0]  op;
		logic [ile_pkg::POS_W-1:0] pos;
		int                        pick;
		bit                        growing;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = '0;
		position     = '0;
		item_value   = '0;
		burst_left   = 0;
		shadow_len   = 0;
		hold_off_req = 1'b0;
		growing      = 1'b1;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: get, remove, set and insert on an empty list, edges of the insert
		// range, middle and top removal, spare codes, then fill to capacity.
		send_item(ile_pkg::OP_GET,    5'd0,  32'sd1);
		send_item(ile_pkg::OP_REMOVE, 5'd0,  32'sd2);
		send_item(ile_pkg::OP_SET,    5'd0,  32'sd3);
		send_item(ile_pkg::OP_INSERT, 5'd1,  32'sd4);
		send_item(ile_pkg::OP_INSERT, 5'd0,  32'sh7fffffff);
		send_item(ile_pkg::OP_APPEND, 5'd0,  32'sh80000000);
		send_item(ile_pkg::OP_INSERT, 5'd2,  -32'sd1);
		send_item(ile_pkg::OP_INSERT, 5'd1,  32'sh12345678);
		send_item(ile_pkg::OP_GET,    5'd1,  32'sd0);
		send_item(ile_pkg::OP_GET,    5'd4,  32'sd0);
		send_item(ile_pkg::OP_SET,    5'd0,  32'shdeadbeef);
		send_item(ile_pkg::OP_REMOVE, 5'd1,  32'sd0);
		send_item(ile_pkg::OP_REMOVE, 5'd2,  32'sd0);
		send_item(OP_SPARE_6, 5'd31, 32'shffffffff);
		send_item(OP_SPARE_7, 5'd21, 32'shaaaaaaaa);
		send_item(ile_pkg::OP_GET,    5'd31, 32'sh55555555);
		while (shadow_len < CAPACITY) begin
			send_item(ile_pkg::OP_APPEND, 5'd0, random_word());
		end
		send_item(ile_pkg::OP_APPEND, 5'd0,  32'sd5);
		send_item(ile_pkg::OP_INSERT, 5'd16, 32'sd6);
		send_item(ile_pkg::OP_INSERT, 5'd17, 32'sd7);
		send_item(ile_pkg::OP_GET,    5'd15, 32'sd0);
		send_item(ile_pkg::OP_REMOVE, 5'd15, 32'sd0);
		send_item(ile_pkg::OP_CLEAR,  5'd0,  32'sd0);

		// Random: mostly in-range requests that grow the list to full and shrink
		// it back, with rare clears, spare codes and out-of-range positions.
		hold_off_req = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (shadow_len == CAPACITY) begin
				growing = 1'b0;
			end else if (shadow_len == 0) begin
				growing = 1'b1;
			end else if ($urandom_range(0, 39) == 0) begin
				growing = !growing;
			end
			pick = $urandom_range(0, 99);
			if (pick < 1) begin
				op = ile_pkg::OP_CLEAR;
			end else if (pick < 4) begin
				op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
			end else begin
				pick = $urandom_range(0, 99);
				if (growing) begin
					op = (pick < 35) ? ile_pkg::OP_APPEND : (pick < 65) ? ile_pkg::OP_INSERT
						: (pick < 78) ? ile_pkg::OP_GET : (pick < 90) ? ile_pkg::OP_SET
						: ile_pkg::OP_REMOVE;
				end else begin
					op = (pick < 45) ? ile_pkg::OP_REMOVE : (pick < 65) ? ile_pkg::OP_GET
						: (pick < 80) ? ile_pkg::OP_SET : (pick < 90) ? ile_pkg::OP_INSERT
						: ile_pkg::OP_APPEND;
				end
			end
			if ($urandom_range(0, 15) == 0) begin
				pos = pos_t'($urandom_range(0, 31));
			end else if (op == ile_pkg::OP_INSERT) begin
				pos = pos_t'($urandom_range(0, shadow_len));
			end else begin
				pos = (shadow_len > 0) ? pos_t'($urandom_range(0, shadow_len - 1)) : '0;
			end
			send_item(op, pos, random_word());
		end
		in_valid <= 1'b0;

		// Drain what is still owed, then let the result path settle.
		while (results_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_total == 0 && results_owed == 0) begin
			$display("** indexed_list_engine: PASSED **");
		end else begin
			$display("** indexed_list_engine: FAILED **");
		end
		$finish;
	end

endmodule
